>>> hdl/rrqs_pkg.sv
// Shared types and constants of the round-robin quantum scheduler.
package rrqs_pkg;

  localparam int TASK_ID_W           = 4;
  localparam int OWNER_W             = TASK_ID_W + 1;
  localparam int SLICE_W             = 8;
  localparam int DEFAULT_MAX_TASKS   = 16;
  localparam int DEFAULT_NUM_MUTEXES = 3;

  localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd2;
  localparam logic [SLICE_W-1:0] SLICE_MAX     = 8'hFF;

  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [1:0] EFF_NONE   = 2'd0;
  localparam logic [1:0] EFF_WAIT   = 2'd1;
  localparam logic [1:0] EFF_SIGNAL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_RAN        = 3'd1,
    ST_TERMINATED = 3'd2,
    ST_FINISHED   = 3'd3,
    ST_REQUEUE    = 3'd4,
    ST_BLOCKED    = 3'd5,
    ST_ADMITTED   = 3'd6,
    ST_FULL       = 3'd7
  } status_t;

  // Commands to the ready queue: push_a is written before push_b.
  typedef struct packed {
    logic rd;
    logic pop;
    logic push_a;
    logic push_b;
  } rq_cmd_t;

  // Commands to the mutex wait queues, all for the selected mutex.
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } wq_cmd_t;

endpackage

>>> hdl/round_robin_quantum_scheduler.sv
// Top level of the round-robin quantum scheduler: sequencer, task state and queues.
//
// Usage. Words enter on the in_ stream: in_tuser[0] selects admit (0) or scheduling
// tick (1); in_tdata carries the task id and the outcome of the running task's
// instruction. Every accepted word yields exactly one result word on the out_
// stream. cfg_we with cfg_wdata sets the time quantum; write it only while idle.
//
// Timing. A word is accepted in the idle state. That edge also issues the reads
// of the ready queue head and of the selected mutex's wait queue head, both held
// in synchronous memories with registered read data. In the execute state the
// queues and task state are updated and the result enters the output register,
// which drives out_tvalid. A new word is accepted only in the idle state, after
// the update of the last one, as the memory reads must be registered first.
//
// Stalls. The output register holds a finished word while the next input word
// is accepted and read; the update only completes once the output register has
// been freed by out_tready, so a stalled receiver holds the block in its update.
//
// Reset. rst_n clears the queue pointers and counts, the running task, the slice
// count and the mutex owners, and sets the quantum to two. No clearing pass.
module round_robin_quantum_scheduler #(
  parameter int MAX_TASKS   = rrqs_pkg::DEFAULT_MAX_TASKS,
  parameter int NUM_MUTEXES = rrqs_pkg::DEFAULT_NUM_MUTEXES
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, low bit up: task_id[3:0], has_instruction[4], effect[6:5],
  // mutex_id[8:7], reaches_end[9], zero fill[15:10]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // in_tuser: action[0]
  input  logic [0:0]  in_tuser,
  // out_tdata, low bit up: status[2:0], dispatched[3], current_id[7:4],
  // woke_valid[8], woke_id[12:9], zero fill[15:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int IDW = rrqs_pkg::TASK_ID_W;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int MW  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int SW  = rrqs_pkg::SLICE_W;
  localparam int OW  = rrqs_pkg::OWNER_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Word captured at acceptance.
  logic           act_r;
  logic [IDW-1:0] tid_r;
  logic           hasi_r;
  logic [1:0]     eff_r;
  logic           end_r;
  logic [MW-1:0]  sel_r;
  logic           mvalid_r;

  // Task and scheduling state.
  logic           run_v_r, run_v_nxt;
  logic [IDW-1:0] run_id_r, run_id_nxt;
  logic [SW-1:0]  slice_r, slice_nxt;
  logic [SW-1:0]  quantum_r;
  logic [OW-1:0]  owner_r [NUM_MUTEXES];

  // Output register.
  logic           out_valid_r;
  logic [15:0]    out_data_r;

  logic           accept, commit;
  logic [1:0]     in_mid;
  logic           in_mvalid;
  logic [MW-1:0]  in_sel, mutex_sel;

  rrqs_pkg::rq_cmd_t rq_cmd;
  rrqs_pkg::wq_cmd_t wq_cmd;
  logic [IDW-1:0]    rq_rd_id, wq_rd_id;
  logic [IDW-1:0]    rq_a_id, rq_b_id;
  logic [CW-1:0]     rq_count, wq_count;

  // Update decisions of the execute cycle.
  rrqs_pkg::status_t st;
  logic           disp, wv, blocked;
  logic [IDW-1:0] cur, wid;
  logic [CW-1:0]  cnt1, cnt2;
  logic [SW-1:0]  slice_inc;
  logic           own_we;
  logic [OW-1:0]  own_val;
  logic           rq_pop, rq_pa, rq_pb, wq_push, wq_pop;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Unknown mutex ids are mapped onto mutex zero; the valid flag blocks any effect.
  assign in_mid    = in_tdata[8:7];
  assign in_mvalid = int'(in_mid) < NUM_MUTEXES;
  assign in_sel    = in_mvalid ? MW'(in_mid) : '0;
  assign mutex_sel = (state_r == S_IDLE) ? in_sel : sel_r;

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = commit ? S_IDLE : S_EXEC;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign slice_inc = (slice_r == rrqs_pkg::SLICE_MAX) ? slice_r : slice_r + SW'(1);

  always_comb begin
    st         = rrqs_pkg::ST_IDLE;
    disp       = 1'b0;
    cur        = '0;
    wv         = 1'b0;
    wid        = '0;
    blocked    = 1'b0;
    run_v_nxt  = run_v_r;
    run_id_nxt = run_id_r;
    slice_nxt  = slice_r;
    own_we     = 1'b0;
    own_val    = '0;
    rq_pop     = 1'b0;
    rq_pa      = 1'b0;
    rq_pb      = 1'b0;
    rq_a_id    = tid_r;
    rq_b_id    = run_id_r;
    wq_push    = 1'b0;
    wq_pop     = 1'b0;
    cnt1       = rq_count;
    cnt2       = rq_count;
    if (act_r == rrqs_pkg::ACT_ADMIT) begin
      cur = tid_r;
      if (rq_count < CW'(MAX_TASKS)) begin
        rq_pa = 1'b1;
        st    = rrqs_pkg::ST_ADMITTED;
      end else begin
        st = rrqs_pkg::ST_FULL;
      end
    end else if (run_v_r || (rq_count != '0)) begin
      // Dispatch the head of the ready queue when nothing runs.
      if (!run_v_r) begin
        disp   = 1'b1;
        rq_pop = 1'b1;
        cnt1   = rq_count - CW'(1);
        cur    = rq_rd_id;
      end else begin
        cur = run_id_r;
      end
      cnt2       = cnt1;
      run_v_nxt  = 1'b1;
      run_id_nxt = cur;
      rq_b_id    = cur;
      if (!hasi_r) begin
        st        = rrqs_pkg::ST_TERMINATED;
        run_v_nxt = 1'b0;
        slice_nxt = '0;
      end else begin
        slice_nxt = slice_inc;
        if (eff_r == rrqs_pkg::EFF_WAIT && mvalid_r && wq_count < CW'(MAX_TASKS)) begin
          wq_push = 1'b1;
          blocked = 1'b1;
        end else if (eff_r == rrqs_pkg::EFF_SIGNAL && mvalid_r) begin
          if (wq_count == '0) begin
            own_we  = 1'b1;
            own_val = '0;
          end else if (cnt1 < CW'(MAX_TASKS)) begin
            // The woken waiter goes to the ready tail ahead of any requeue.
            wq_pop  = 1'b1;
            rq_pa   = 1'b1;
            rq_a_id = wq_rd_id;
            cnt2    = cnt1 + CW'(1);
            own_we  = 1'b1;
            own_val = OW'(wq_rd_id) + OW'(1);
            wv      = 1'b1;
            wid     = wq_rd_id;
          end
        end
        if (blocked) begin
          st        = rrqs_pkg::ST_BLOCKED;
          run_v_nxt = 1'b0;
          slice_nxt = '0;
        end else if (end_r) begin
          st        = rrqs_pkg::ST_FINISHED;
          run_v_nxt = 1'b0;
          slice_nxt = '0;
        end else if (slice_inc >= quantum_r) begin
          slice_nxt = '0;
          if (cnt2 < CW'(MAX_TASKS)) begin
            rq_pb     = 1'b1;
            st        = rrqs_pkg::ST_REQUEUE;
            run_v_nxt = 1'b0;
          end else begin
            // Ready queue full: the task keeps the processor for another slice.
            st = rrqs_pkg::ST_RAN;
          end
        end else begin
          st = rrqs_pkg::ST_RAN;
        end
      end
    end
  end

  always_comb begin
    rq_cmd.rd     = accept;
    rq_cmd.pop    = commit && rq_pop;
    rq_cmd.push_a = commit && rq_pa;
    rq_cmd.push_b = commit && rq_pb;
    wq_cmd.rd     = accept;
    wq_cmd.pop    = commit && wq_pop;
    wq_cmd.push   = commit && wq_push;
  end

  rrqs_ready_q #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ready_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rq_cmd),
    .push_a_id (rq_a_id),
    .push_b_id (rq_b_id),
    .rd_id     (rq_rd_id),
    .count     (rq_count)
  );

  rrqs_wait_q #(
    .MAX_TASKS   (MAX_TASKS),
    .NUM_MUTEXES (NUM_MUTEXES)
  ) u_wait_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .sel     (mutex_sel),
    .cmd     (wq_cmd),
    .push_id (cur),
    .rd_id   (wq_rd_id),
    .count   (wq_count)
  );

  // Captured input word and output data; payload only, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_tuser[0];
      tid_r    <= in_tdata[3:0];
      hasi_r   <= in_tdata[4];
      eff_r    <= in_tdata[6:5];
      end_r    <= in_tdata[9];
      sel_r    <= in_sel;
      mvalid_r <= in_mvalid;
    end
    if (commit) begin
      out_data_r <= {3'b000, wid, wv, cur, disp, st};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_v_r     <= 1'b0;
      run_id_r    <= '0;
      slice_r     <= '0;
      quantum_r   <= rrqs_pkg::QUANTUM_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        owner_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (commit) begin
        run_v_r  <= run_v_nxt;
        run_id_r <= run_id_nxt;
        slice_r  <= slice_nxt;
        if (own_we) begin
          owner_r[sel_r] <= own_val;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // An accepted word always moves the sequencer into its update cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted word did not start an update");

  // Any status that ends a slice without keeping the task leaves nothing running.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (st == rrqs_pkg::ST_BLOCKED || st == rrqs_pkg::ST_FINISHED ||
               st == rrqs_pkg::ST_TERMINATED || st == rrqs_pkg::ST_REQUEUE)
    |=> !run_v_r)
    else $error("task still running after release");

  // A woken waiter must sit in the ready queue afterwards.
  a_wake_ready: assert property (@(posedge clk) disable iff (!rst_n)
    commit && wv |=> (rq_count != '0))
    else $error("woken task missing from ready queue");
`endif

endmodule

>>> hdl/rrqs_ready_q.sv
// Ready queue of task ids: circular buffer in a synchronous memory.
module rrqs_ready_q #(
  parameter int MAX_TASKS = rrqs_pkg::DEFAULT_MAX_TASKS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rrqs_pkg::rq_cmd_t              cmd,
  input  logic [rrqs_pkg::TASK_ID_W-1:0] push_a_id,
  input  logic [rrqs_pkg::TASK_ID_W-1:0] push_b_id,
  output logic [rrqs_pkg::TASK_ID_W-1:0] rd_id,
  output logic [$clog2(MAX_TASKS+1)-1:0] count
);

  localparam int PW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [rrqs_pkg::TASK_ID_W-1:0] mem [MAX_TASKS];
  logic [rrqs_pkg::TASK_ID_W-1:0] rd_id_r;
  logic [PW-1:0]                  head_r, head_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           pend_v_r;
  logic [PW-1:0]                  pend_addr_r;
  logic [rrqs_pkg::TASK_ID_W-1:0] pend_id_r;

  logic [PW-1:0]                  head_pop, tail0, tail1;
  logic [CW-1:0]                  cnt_pop;
  logic                           wr_en;
  logic [PW-1:0]                  wr_addr;
  logic [rrqs_pkg::TASK_ID_W-1:0] wr_data;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(MAX_TASKS)) begin
      s = s - (CW+1)'(MAX_TASKS);
    end
    return s[PW-1:0];
  endfunction

  always_comb begin
    head_pop  = cmd.pop ? wrap_add(head_r, CW'(1)) : head_r;
    cnt_pop   = count_r - CW'(cmd.pop);
    tail0     = wrap_add(head_pop, cnt_pop);
    tail1     = wrap_add(head_pop, cnt_pop + CW'(1));
    head_nxt  = head_pop;
    count_nxt = cnt_pop + CW'(cmd.push_a) + CW'(cmd.push_b);
  end

  // A second push in the same cycle is parked in a register and written in the cycle after.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail0;
    wr_data = push_a_id;
    if (pend_v_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = pend_id_r;
    end else if (cmd.push_a) begin
      wr_en = 1'b1;
    end else if (cmd.push_b) begin
      wr_en   = 1'b1;
      wr_data = push_b_id;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_id_r <= mem[head_r];
    end
    pend_addr_r <= tail1;
    pend_id_r   <= push_b_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      pend_v_r <= cmd.push_a && cmd.push_b;
    end
  end

  assign rd_id = rd_id_r;
  assign count = count_r;

endmodule

>>> hdl/rrqs_wait_q.sv
// Per-mutex wait queues sharing one synchronous memory, one region per mutex.
module rrqs_wait_q #(
  parameter int MAX_TASKS   = rrqs_pkg::DEFAULT_MAX_TASKS,
  parameter int NUM_MUTEXES = rrqs_pkg::DEFAULT_NUM_MUTEXES
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic [((NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1)-1:0] sel,
  input  rrqs_pkg::wq_cmd_t                                   cmd,
  input  logic [rrqs_pkg::TASK_ID_W-1:0]                      push_id,
  output logic [rrqs_pkg::TASK_ID_W-1:0]                      rd_id,
  output logic [$clog2(MAX_TASKS+1)-1:0]                      count
);

  localparam int PW    = $clog2(MAX_TASKS);
  localparam int CW    = $clog2(MAX_TASKS + 1);
  localparam int DEPTH = NUM_MUTEXES * MAX_TASKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [rrqs_pkg::TASK_ID_W-1:0] mem [DEPTH];
  logic [rrqs_pkg::TASK_ID_W-1:0] rd_id_r;
  logic [PW-1:0]                  head_r  [NUM_MUTEXES];
  logic [CW-1:0]                  count_r [NUM_MUTEXES];

  logic [PW-1:0] head_sel, tail_sel;
  logic [CW-1:0] count_sel;
  logic [AW-1:0] rd_addr, wr_addr;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(MAX_TASKS)) begin
      s = s - (CW+1)'(MAX_TASKS);
    end
    return s[PW-1:0];
  endfunction

  always_comb begin
    head_sel  = head_r[sel];
    count_sel = count_r[sel];
    tail_sel  = wrap_add(head_sel, count_sel);
    rd_addr   = AW'(int'(sel) * MAX_TASKS + int'(head_sel));
    wr_addr   = AW'(int'(sel) * MAX_TASKS + int'(tail_sel));
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_id;
    end
    if (cmd.rd) begin
      rd_id_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      if (cmd.pop) begin
        head_r[sel]  <= wrap_add(head_sel, CW'(1));
        count_r[sel] <= count_sel - CW'(1);
      end else if (cmd.push) begin
        count_r[sel] <= count_sel + CW'(1);
      end
    end
  end

  assign rd_id = rd_id_r;
  assign count = count_sel;

endmodule

>>> tb/rrqs_outcome_checker.sv
// Scheduler outcome checker: predicts every result word and compares it with the block's output.
module rrqs_outcome_checker
  import rrqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TASKS   = DEFAULT_MAX_TASKS;
  localparam int NUM_MUTEXES = DEFAULT_NUM_MUTEXES;

  typedef struct packed {
    status_t              status;
    logic                 dispatched;
    logic [TASK_ID_W-1:0] current_id;
    logic                 woke_valid;
    logic [TASK_ID_W-1:0] woke_id;
  } outcome_t;

  // Shadow copy of the scheduler state.
  logic [TASK_ID_W-1:0] ready_ids [MAX_TASKS];
  int                   ready_head;
  int                   ready_count;
  logic [TASK_ID_W-1:0] wait_ids [NUM_MUTEXES][MAX_TASKS];
  int                   wait_head [NUM_MUTEXES];
  int                   wait_count [NUM_MUTEXES];
  logic                 running;
  logic [TASK_ID_W-1:0] run_id;
  logic [SLICE_W-1:0]   slice;
  logic [SLICE_W-1:0]   quantum;
  logic [OWNER_W-1:0]   owner [NUM_MUTEXES];

  outcome_t outcome_q[$];
  outcome_t want;
  int       fail_total;

  assign fail_count = fail_total;

  function automatic bit push_ready(logic [TASK_ID_W-1:0] id);
    if (ready_count >= MAX_TASKS) return 1'b0;
    ready_ids[(ready_head + ready_count) % MAX_TASKS] = id;
    ready_count++;
    return 1'b1;
  endfunction

  function automatic outcome_t predict_outcome(logic act, logic [TASK_ID_W-1:0] tid,
      logic has_instr, logic [1:0] eff, logic [1:0] mid, logic at_end);
    outcome_t             o;
    logic [TASK_ID_W-1:0] woken;
    bit                   runs;
    bit                   blocked;
    o = '0;
    o.status = ST_IDLE;
    if (act == ACT_ADMIT) begin
      o.status = push_ready(tid) ? ST_ADMITTED : ST_FULL;
      o.current_id = tid;
      return o;
    end
    runs = running;
    if (!running && ready_count != 0) begin
      run_id = ready_ids[ready_head];
      ready_head = (ready_head + 1) % MAX_TASKS;
      ready_count--;
      running = 1'b1;
      runs = 1'b1;
      o.dispatched = 1'b1;
    end
    if (!runs) return o;
    o.current_id = run_id;
    if (!has_instr) begin
      o.status = ST_TERMINATED;
      running = 1'b0;
      slice = '0;
      return o;
    end
    if (slice != SLICE_MAX) slice++;
    blocked = 1'b0;
    if (eff == EFF_WAIT && mid < NUM_MUTEXES && wait_count[mid] < MAX_TASKS) begin
      wait_ids[mid][(wait_head[mid] + wait_count[mid]) % MAX_TASKS] = run_id;
      wait_count[mid]++;
      blocked = 1'b1;
    end else if (eff == EFF_SIGNAL && mid < NUM_MUTEXES) begin
      if (wait_count[mid] == 0) begin
        owner[mid] = '0;
      end else if (ready_count < MAX_TASKS) begin
        // The woken waiter goes into the ready queue ahead of any requeue below.
        woken = wait_ids[mid][wait_head[mid]];
        wait_head[mid] = (wait_head[mid] + 1) % MAX_TASKS;
        wait_count[mid]--;
        void'(push_ready(woken));
        owner[mid] = {1'b0, woken} + 1'b1;
        o.woke_valid = 1'b1;
        o.woke_id = woken;
      end
    end
    if (blocked) begin
      o.status = ST_BLOCKED;
      running = 1'b0;
      slice = '0;
    end else if (at_end) begin
      o.status = ST_FINISHED;
      running = 1'b0;
      slice = '0;
    end else if (slice >= quantum) begin
      slice = '0;
      if (push_ready(run_id)) begin
        o.status = ST_REQUEUE;
        running = 1'b0;
      end else begin
        o.status = ST_RAN;
      end
    end else begin
      o.status = ST_RAN;
    end
    return o;
  endfunction

  task automatic check_field(string name, int unsigned expected_val, int unsigned actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
      fail_total++;
    end
  endtask

  initial fail_total = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_head  = 0;
      ready_count = 0;
      for (int m = 0; m < NUM_MUTEXES; m++) begin
        wait_head[m]  = 0;
        wait_count[m] = 0;
        owner[m]      = '0;
      end
      running = 1'b0;
      run_id  = '0;
      slice   = '0;
      quantum = QUANTUM_RESET;
      outcome_q.delete();
    end else begin
      if (cfg_we) quantum = cfg_wdata;
      // A result accepted at this edge always belongs to an earlier word.
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result word 0x%h arrived with no prediction waiting", out_tdata);
          fail_total++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", want.status, out_tdata[2:0]);
          check_field("dispatched", want.dispatched, out_tdata[3]);
          check_field("current_id", want.current_id, out_tdata[7:4]);
          check_field("woke_valid", want.woke_valid, out_tdata[8]);
          check_field("woke_id", want.woke_id, out_tdata[12:9]);
        end
      end
      if (in_tvalid && in_tready)
        outcome_q.push_back(predict_outcome(in_tuser[0], in_tdata[3:0], in_tdata[4],
                                            in_tdata[6:5], in_tdata[8:7], in_tdata[9]));
    end
    words_in_flight <= outcome_q.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the scheduler testbench: clock, reset, stimulus, receiver stalls and the verdict.
module tb_top;
  import rrqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Effect code three behaves as no effect; mutex id three names no real mutex.
  localparam logic [1:0] EFF_SPARE   = 2'd3;
  localparam logic [1:0] MTX_INPUT   = 2'd0;
  localparam logic [1:0] MTX_OUTPUT  = 2'd1;
  localparam logic [1:0] MTX_FILE    = 2'd2;
  localparam logic [1:0] MTX_UNKNOWN = 2'd3;

  localparam int TOTAL_WORDS    = 950;
  localparam int NUM_PHASES     = 6;
  // Every word gives exactly one result; even long random
  // stalls stay far below this many cycles without any handshake.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // in_tdata, low bit up: task_id[3:0], has_instruction[4], effect[6:5],
  // mutex_id[8:7], reaches_end[9], zero fill[15:10]
  logic [15:0] in_tdata;
  // in_tuser: action[0]
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // out_tdata, low bit up: status[2:0], dispatched[3], current_id[7:4],
  // woke_valid[8], woke_id[12:9], zero fill[15:13]
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  int fail_count;
  int words_in_flight;
  int words_sent;
  int quiet_cycles;
  bit gaps_on;
  bit stalls_on;

  round_robin_quantum_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  rrqs_outcome_checker outcome_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .words_in_flight (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops out_tready in about one cycle of six while stalls are on.
  always @(posedge clk) begin
    out_tready <= !(stalls_on && $urandom_range(99) < 17);
  end

  // The run is aborted once no word has moved on either stream for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word and returns at the edge that accepts it. It must be called right
  // after a rising edge. A word that follows without a gap keeps in_tvalid high, so
  // the valid is never lowered and raised within one time step.
  task automatic send_word(logic act, logic [3:0] tid, logic has_instr, logic [1:0] eff,
                           logic [1:0] mid, logic at_end);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'b0, at_end, mid, eff, has_instr, tid};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // The tick fields are ignored on an admit, so they are filled with random bits.
  task automatic admit(logic [3:0] tid);
    send_word(ACT_ADMIT, tid, 1'($urandom_range(1)), 2'($urandom_range(3)),
              2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // The task id field is ignored on a tick, so it carries random bits.
  task automatic tick(logic has_instr, logic [1:0] eff, logic [1:0] mid, logic at_end);
    send_word(ACT_TICK, 4'($urandom_range(15)), has_instr, eff, mid, at_end);
  endtask

  // Waits until every predicted result has been taken.
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] quanta [NUM_PHASES];
    logic [1:0] eff;
    logic [1:0] mid;
    int         roll;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    words_sent = 0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;

    // The first phase runs with the quantum of two left by reset; the others cover
    // one, the largest, zero (every instruction expires the slice) and more.
    quanta = '{QUANTUM_RESET, 8'd1, 8'd255, 8'd0, 8'($urandom_range(4, 254)), 8'd3};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, with the reset quantum of two.
    tick(1'b1, EFF_NONE, MTX_INPUT, 1'b0);      // nothing ready: idle tick
    admit(4'd0);
    admit(4'd15);
    tick(1'b1, EFF_NONE, MTX_INPUT, 1'b0);      // dispatches task 0, which runs
    tick(1'b1, EFF_NONE, MTX_INPUT, 1'b0);      // slice reaches two: task 0 requeued
    tick(1'b1, EFF_WAIT, MTX_INPUT, 1'b0);      // task 15 blocks on the input mutex
    tick(1'b1, EFF_WAIT, MTX_UNKNOWN, 1'b0);    // unknown mutex: an ordinary instruction
    tick(1'b1, EFF_SPARE, MTX_FILE, 1'b1);      // effect three acts as none; task finishes
    admit(4'd10);
    tick(1'b1, EFF_SIGNAL, MTX_INPUT, 1'b0);    // task 10 signals and wakes task 15
    tick(1'b1, EFF_SIGNAL, MTX_OUTPUT, 1'b0);   // no waiter; then requeued behind 15
    tick(1'b0, EFF_NONE, MTX_INPUT, 1'b0);      // task 15 has nothing left: terminated
    tick(1'b1, EFF_WAIT, MTX_FILE, 1'b1);       // blocking wins over reaching the end
    tick(1'b1, EFF_SIGNAL, MTX_UNKNOWN, 1'b1);  // ready queue empty again: idle
    admit(4'd5);
    tick(1'b1, EFF_SIGNAL, MTX_FILE, 1'b1);     // wakes task 10 and finishes task 5
    tick(1'b1, EFF_NONE, MTX_OUTPUT, 1'b0);     // task 10 dispatched and runs
    tick(1'b0, EFF_SIGNAL, MTX_OUTPUT, 1'b1);   // then terminates

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= quanta[phase];
        @(posedge clk);
        cfg_we    <= 1'b0;
      end
      // One whole phase runs with no gaps and no stalls at all.
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);

      while (words_sent < TOTAL_WORDS * (phase + 1) / NUM_PHASES) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            // Admits in a row, often enough to fill the ready queue.
            repeat ($urandom_range(1, 18)) admit(4'($urandom_range(15)));
          end
          3, 4, 5: begin
            // Ticks with a typical mix of instruction outcomes.
            repeat ($urandom_range(1, 12)) begin
              roll = $urandom_range(99);
              eff = (roll < 50) ? EFF_NONE : (roll < 70) ? EFF_WAIT :
                    (roll < 95) ? EFF_SIGNAL : EFF_SPARE;
              mid = ($urandom_range(19) == 0) ? MTX_UNKNOWN : 2'($urandom_range(MTX_FILE));
              tick($urandom_range(99) < 92, eff, mid, $urandom_range(9) == 0);
            end
          end
          6: begin
            // Piles tasks onto one mutex until its wait queue may overflow.
            mid = 2'($urandom_range(MTX_FILE));
            repeat ($urandom_range(4, 20)) begin
              admit(4'($urandom_range(15)));
              tick(1'b1, EFF_WAIT, mid, 1'b0);
            end
          end
          7: begin
            // Loads the ready queue, then releases one mutex a few times, so that a
            // waiter sometimes finds no room to wake into.
            mid = 2'($urandom_range(MTX_FILE));
            repeat ($urandom_range(0, 17)) admit(4'($urandom_range(15)));
            repeat ($urandom_range(1, 4)) tick(1'b1, EFF_SIGNAL, mid, $urandom_range(7) == 0);
          end
          8: begin
            // Unshaped noise over every field.
            repeat ($urandom_range(1, 8))
              send_word(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                        2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
          end
          default: begin
            // Ticks that mostly end tasks, which drains a crowded ready queue.
            repeat ($urandom_range(1, 10))
              tick(1'($urandom_range(1)), EFF_NONE, 2'($urandom_range(3)),
                   1'($urandom_range(1)));
          end
        endcase
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rrqs_pkg.sv
hdl/rrqs_ready_q.sv
hdl/rrqs_wait_q.sv
hdl/round_robin_quantum_scheduler.sv
tb/rrqs_outcome_checker.sv
tb/tb_top.sv
